FILE: rtl/srt_pkg.sv
`default_nettype none

package srt_pkg;

    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 8;
    localparam int ALPHA_N   = 16;
    localparam int DIGIT_W   = 4;
    localparam int BASE_W    = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int DIGIT_N   = 32;
    localparam int ND_W      = 6;
    localparam int SLICE_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

    typedef logic [ALPHA_N*CHAR_W-1:0] t_alphabet;

    typedef struct packed {
        logic               err;
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_job;

endpackage

`default_nettype wire

FILE: rtl/signed_radix_to_text.sv
// channel  | handshake                  | beat payload
// ---------+----------------------------+--------------------------------------
// input    | i_in_valid / o_in_stall    | i_value
// output   | o_out_valid / i_out_stall  | o_out_char, o_is_last, o_base_error
// config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// An item leaves the queue, the divider produces its digits one by one
// (8 quotient bits per cycle against the 5-bit radix), then the beats follow.
// A two-entry queue decouples input acceptance from digit generation.
// Reset is synchronous, active low; config registers reset to zero.
// Output stall holds the output register and pauses the emit sequence.
`default_nettype none

module signed_radix_to_text #(
    parameter int MAX_BASE = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [srt_pkg::VALUE_W-1:0] i_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [srt_pkg::CHAR_W-1:0]              o_out_char,
    output logic                                    o_is_last,
    output logic                                    o_base_error,
    input  wire logic                               i_cfg_we,
    input  wire logic [srt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [srt_pkg::CFG_W-1:0]          i_cfg_data
);
    import srt_pkg::*;

    logic [BASE_W-1:0] r_base_len;
    logic [CFG_W-1:0]  r_alpha_low;
    logic [CFG_W-1:0]  r_alpha_high;

    t_alphabet alphabet;
    t_job      push_job;
    t_job      head_job;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_len   <= '0;
            r_alpha_low  <= '0;
            r_alpha_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_LEN:   r_base_len   <= i_cfg_data[BASE_W-1:0];
                CFG_ALPHA_LOW:  r_alpha_low  <= i_cfg_data;
                CFG_ALPHA_HIGH: r_alpha_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign alphabet = {r_alpha_high, r_alpha_low};

    srt_front #(
        .MAX_BASE(MAX_BASE)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_value    (i_value),
        .i_base_len (r_base_len),
        .i_alphabet (alphabet),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_job    (push_job)
    );

    srt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    srt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_job      (head_job),
        .o_q_pop      (q_pop),
        .i_base_len   (r_base_len),
        .i_alphabet   (alphabet),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_char   (o_out_char),
        .o_is_last    (o_is_last),
        .o_base_error (o_base_error)
    );

endmodule

`default_nettype wire

FILE: rtl/srt_front.sv
`default_nettype none

module srt_front #(
    parameter int MAX_BASE = 16
) (
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic signed [srt_pkg::VALUE_W-1:0] i_value,
    input  wire logic [srt_pkg::BASE_W-1:0]        i_base_len,
    input  wire srt_pkg::t_alphabet                i_alphabet,
    input  wire logic                              i_q_full,
    output logic                                   o_q_push,
    output srt_pkg::t_job                          o_q_job
);
    import srt_pkg::*;

    logic               ok;
    logic [VALUE_W-1:0] raw;

    // alphabet check: radix range, no sign chars, no repeats among used chars
    always_comb begin
        ok = (i_base_len >= BASE_W'(2)) && (i_base_len <= BASE_W'(MAX_BASE));
        for (int a = 0; a < ALPHA_N; a++) begin
            if (BASE_W'(a) < i_base_len) begin
                if (i_alphabet[a*CHAR_W +: CHAR_W] == CHAR_MINUS ||
                    i_alphabet[a*CHAR_W +: CHAR_W] == CHAR_PLUS) begin
                    ok = 1'b0;
                end
                for (int b = a + 1; b < ALPHA_N; b++) begin
                    if (BASE_W'(b) < i_base_len &&
                        i_alphabet[b*CHAR_W +: CHAR_W] ==
                        i_alphabet[a*CHAR_W +: CHAR_W]) begin
                        ok = 1'b0;
                    end
                end
            end
        end
    end

    assign raw         = VALUE_W'(i_value);
    assign o_q_job.err = !ok;
    assign o_q_job.neg = raw[VALUE_W-1];
    assign o_q_job.mag = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
    assign o_q_push    = i_in_valid && !i_q_full;
    assign o_in_stall  = i_q_full;

endmodule

`default_nettype wire

FILE: rtl/srt_queue.sv
`default_nettype none

module srt_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire srt_pkg::t_job i_job,
    input  wire logic          i_pop,
    output srt_pkg::t_job      o_job,
    output logic               o_full,
    output logic               o_empty
);
    import srt_pkg::*;

    t_job       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    assign o_job   = r_slot[r_rp];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule

`default_nettype wire

FILE: rtl/srt_back.sv
`default_nettype none

module srt_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_empty,
    input  wire srt_pkg::t_job               i_q_job,
    output logic                             o_q_pop,
    input  wire logic [srt_pkg::BASE_W-1:0]  i_base_len,
    input  wire srt_pkg::t_alphabet          i_alphabet,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [srt_pkg::CHAR_W-1:0]       o_out_char,
    output logic                             o_is_last,
    output logic                             o_base_error
);
    import srt_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ERR  = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]         r_state;
    logic [VALUE_W-1:0] r_mag;
    logic [DIGIT_W-1:0] r_rem;
    logic [1:0]         r_step;
    logic [ND_W-1:0]    r_nd;
    logic [DIGIT_W-1:0] r_digit [DIGIT_N];
    logic [ND_W-2:0]    r_idx;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;
    logic               r_out_err;

    logic [VALUE_W-1:0] n_mag;
    logic [DIGIT_W-1:0] n_rem;
    logic [SLICE_W-1:0] q_bits;
    logic [BASE_W-1:0]  t;
    logic               can_put;
    logic               load_out;

    // restoring division, one byte of dividend per cycle
    always_comb begin
        n_rem  = r_rem;
        q_bits = '0;
        t      = '0;
        for (int i = SLICE_W - 1; i >= 0; i--) begin
            t = {n_rem, r_mag[VALUE_W-SLICE_W+i]};
            if (t >= i_base_len) begin
                q_bits[i] = 1'b1;
                n_rem     = DIGIT_W'(t - i_base_len);
            end else begin
                n_rem = t[DIGIT_W-1:0];
            end
        end
        n_mag = {r_mag[VALUE_W-SLICE_W-1:0], q_bits};
    end

    assign can_put  = !r_out_valid || !i_out_stall;
    // a new beat enters the output register this cycle
    assign load_out = can_put &&
                      (r_state == ST_ERR || r_state == ST_SIGN || r_state == ST_EMIT);
    assign o_q_pop  = (r_state == ST_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= 2'd0;
            r_nd        <= '0;
            r_idx       <= '0;
            r_rem       <= '0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_mag  <= i_q_job.mag;
                        r_rem  <= '0;
                        r_step <= 2'd0;
                        r_nd   <= '0;
                        if (i_q_job.err) begin
                            r_state <= ST_ERR;
                        end else if (i_q_job.neg) begin
                            r_state <= ST_SIGN;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_ERR: begin
                    if (can_put) begin
                        r_out_char  <= '0;
                        r_out_last  <= 1'b1;
                        r_out_err   <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_SIGN: begin
                    if (can_put) begin
                        r_out_char  <= CHAR_MINUS;
                        r_out_last  <= 1'b0;
                        r_out_err   <= 1'b0;
                        r_state     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_mag  <= n_mag;
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        // a digit is complete, n_mag is the quotient
                        r_digit[r_nd[ND_W-2:0]] <= n_rem;
                        r_nd  <= r_nd + ND_W'(1);
                        r_rem <= '0;
                        if (n_mag == '0 || r_nd == ND_W'(DIGIT_N - 1)) begin
                            r_idx   <= r_nd[ND_W-2:0];
                            r_state <= ST_EMIT;
                        end
                    end else begin
                        r_rem <= n_rem;
                    end
                end
                ST_EMIT: begin
                    if (can_put) begin
                        r_out_char  <= i_alphabet[r_digit[r_idx]*CHAR_W +: CHAR_W];
                        r_out_last  <= (r_idx == '0);
                        r_out_err   <= 1'b0;
                        if (r_idx == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx - (ND_W-1)'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_is_last    = r_out_last;
    assign o_base_error = r_out_err;

endmodule

`default_nettype wire
